>>> hw/rtl/smcn_pkg.sv
package smcn_pkg;

    localparam logic [1:0] PH_PEAK    = 2'd0;
    localparam logic [1:0] PH_MEAN_UP = 2'd1;
    localparam logic [1:0] PH_MEAN_LO = 2'd2;
    localparam logic [1:0] PH_NORM    = 2'd3;

    localparam logic [1:0] REG_PHASE        = 2'd0;
    localparam logic [1:0] REG_UPPER_FACTOR = 2'd1;
    localparam logic [1:0] REG_LOWER_FACTOR = 2'd2;
    localparam logic [1:0] REG_INV_COUNT    = 2'd3;

    localparam logic [20:0] BOUND_MAX       = 21'h1FFFFF;
    localparam logic [20:0] PEAK_LOWER_INIT = 21'd844800;

    typedef enum logic [3:0] {
        K_NONE,
        K_KEEP,
        K_CLEAR_PEAK,
        K_CLEAR_UP,
        K_CLEAR_LO,
        K_PEAK,
        K_MEAN_UP,
        K_MEAN_LO,
        K_NORM
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [5:0]  idx;
        logic [11:0] mv;
    } t_job;

    typedef struct packed {
        logic [1:0]  phase;
        logic [15:0] upper_factor;
        logic [15:0] lower_factor;
        logic [23:0] inv_sample_count;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

>>> hw/rtl/smcn_front.sv
module smcn_front import smcn_pkg::*; #(
    parameter int SENSOR_COUNT = 64
) (
    input  logic        i_in_valid,
    input  logic        i_func,
    input  logic [5:0]  i_sensor_index,
    input  logic [11:0] i_millivolts,
    input  logic [1:0]  i_phase,
    input  t_q_stat     i_q_stat,
    output logic        o_in_stall,
    output logic        o_push,
    output t_job        o_job
);

    logic  out_of_range;
    t_kind kind;

    assign out_of_range = {5'b0, i_sensor_index} >= 11'(SENSOR_COUNT);

    always_comb begin
        kind = K_NONE;
        if (!out_of_range) begin
            if (!i_func) begin
                case (i_phase)
                    PH_PEAK:    kind = K_CLEAR_PEAK;
                    PH_MEAN_UP: kind = K_CLEAR_UP;
                    PH_MEAN_LO: kind = K_CLEAR_LO;
                    default:    kind = K_KEEP;
                endcase
            end else begin
                case (i_phase)
                    PH_PEAK:    kind = K_PEAK;
                    PH_MEAN_UP: kind = K_MEAN_UP;
                    PH_MEAN_LO: kind = K_MEAN_LO;
                    default:    kind = K_NORM;
                endcase
            end
        end
    end

    assign o_in_stall = i_q_stat.full;
    assign o_push     = i_in_valid && !i_q_stat.full;
    assign o_job      = '{kind: kind, idx: i_sensor_index, mv: i_millivolts};

endmodule

>>> hw/rtl/smcn_queue.sv
module smcn_queue import smcn_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_head,
    output t_q_stat o_stat
);

    t_job       r_ent [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_job;
        end
    end

    assign o_head       = r_ent[r_rp];
    assign o_stat.full  = r_cnt[1];
    assign o_stat.empty = (r_cnt == 2'd0);

endmodule

>>> hw/rtl/smcn_div.sv
module smcn_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [21:0]        i_mag,
    input  logic [20:0]        i_den,
    input  logic               i_neg,
    output logic               o_done,
    output logic signed [23:0] o_norm,
    output logic               o_sat
);

    localparam logic [4:0]  LAST_STEP = 5'd23;
    localparam logic [23:0] NORM_MAX  = 24'h7FFFFF;
    localparam logic [23:0] NORM_MIN  = 24'h800000;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [21:0] r_rem;
    logic [23:0] r_dvd;
    logic [23:0] r_quo;
    logic [20:0] r_den;
    logic        r_neg;
    logic        r_ovf;

    logic [21:0] trial;
    logic        fits;
    logic        ovf_in;
    logic        pos_sat;
    logic        neg_sat;

    assign trial  = {r_rem[20:0], r_dvd[23]};
    assign fits   = trial >= {1'b0, r_den};
    // quotient would need more than 24 bits
    assign ovf_in = {7'b0, i_mag} >= {i_den, 8'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == 5'd0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {8'b0, i_mag[21:8]};
            r_dvd <= {i_mag[7:0], 16'b0};
            r_den <= i_den;
            r_neg <= i_neg;
            r_ovf <= ovf_in;
            r_cnt <= ovf_in ? 5'd0 : LAST_STEP;
        end else if (r_busy) begin
            r_rem <= fits ? (trial - {1'b0, r_den}) : trial;
            r_quo <= {r_quo[22:0], fits};
            r_dvd <= {r_dvd[22:0], 1'b0};
            r_cnt <= r_cnt - 5'd1;
        end
    end

    assign pos_sat = r_ovf || r_quo[23];
    assign neg_sat = r_ovf || (r_quo[23] && (|r_quo[22:0]));

    always_comb begin
        if (r_neg) begin
            o_sat  = neg_sat;
            o_norm = neg_sat ? NORM_MIN : (~r_quo + 24'd1);
        end else begin
            o_sat  = pos_sat;
            o_norm = pos_sat ? NORM_MAX : r_quo;
        end
    end

    assign o_done = r_done;

endmodule

>>> hw/rtl/smcn_back.sv
module smcn_back import smcn_pkg::*; #(
    parameter int SENSOR_COUNT = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_job               i_head,
    input  t_q_stat            i_q_stat,
    output logic               o_pop,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic signed [23:0] o_norm_value,
    output logic               o_bound_error,
    output logic               o_saturated,
    output logic [20:0]        o_upper_now,
    output logic [20:0]        o_lower_now
);

    localparam int DEPTH = (SENSOR_COUNT < 64) ? SENSOR_COUNT : 64;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_MEAN = 6'b000100,
        S_UPD  = 6'b001000,
        S_DIV  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [41:0]      r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [41:0]      r_rd;
    logic             r_rdv;

    t_job        r_job;
    logic [20:0] r_up, r_lo;
    logic [28:0] r_pu, r_pl;
    logic [20:0] r_mt;
    logic [20:0] r_nu, r_nl;
    logic        r_err;
    logic [23:0] r_norm;
    logic        r_sat;

    logic               r_ov;
    logic signed [23:0] r_o_norm;
    logic               r_o_err;
    logic               r_o_sat;
    logic [20:0]        r_o_up;
    logic [20:0]        r_o_lo;

    logic [AW-1:0] head_addr, job_addr;
    logic [16:0]   scale_u, scale_l;
    logic [28:0]   mean_src;
    logic [52:0]   mean_prod;
    logic [20:0]   s21;
    logic [21:0]   sum_u, sum_l;
    logic [20:0]   upd_u, upd_l;
    logic          upd_err;
    logic          wr_en;
    logic          num_neg;
    logic [21:0]   mag;
    logic [20:0]   den;
    logic          div_start;
    logic          div_done;
    logic [23:0]   div_norm;
    logic          div_sat;
    logic          out_load;

    function automatic logic [AW-1:0] f_addr(t_job j);
        logic [AW+5:0] w;
        w = {{AW{1'b0}}, j.idx};
        if (j.kind == K_NONE) begin
            w = '0;
        end
        return w[AW-1:0];
    endfunction

    assign head_addr = f_addr(i_head);
    assign job_addr  = f_addr(r_job);
    assign o_pop     = (r_state == S_IDLE) && !i_q_stat.empty;

    assign scale_u   = 17'h10000 + {1'b0, i_cfg.upper_factor};
    assign scale_l   = 17'h10000 - {1'b0, i_cfg.lower_factor};
    assign mean_src  = (r_job.kind == K_MEAN_UP) ? r_pu : r_pl;
    assign mean_prod = 53'(mean_src) * 53'(i_cfg.inv_sample_count);

    always_comb begin
        s21   = {1'b0, r_job.mv, 8'b0};
        sum_u = {1'b0, r_up} + {1'b0, r_mt};
        sum_l = {1'b0, r_lo} + {1'b0, r_mt};
        upd_u = r_up;
        upd_l = r_lo;
        case (r_job.kind)
            K_NONE: begin
                upd_u = '0;
                upd_l = '0;
            end
            K_CLEAR_PEAK: begin
                upd_u = '0;
                upd_l = PEAK_LOWER_INIT;
            end
            K_CLEAR_UP: upd_u = '0;
            K_CLEAR_LO: upd_l = '0;
            K_PEAK: begin
                if (s21 > r_up) begin
                    upd_u = r_pu[28:8];
                end
                if (s21 < r_lo) begin
                    upd_l = r_pl[28:8];
                end
            end
            K_MEAN_UP: upd_u = sum_u[21] ? BOUND_MAX : sum_u[20:0];
            K_MEAN_LO: upd_l = sum_l[21] ? BOUND_MAX : sum_l[20:0];
            default: ;
        endcase
        upd_err = (r_job.kind != K_NONE) && (upd_u <= upd_l);
        num_neg = s21 < r_lo;
        mag     = num_neg ? ({1'b0, r_lo} - {1'b0, s21}) : ({1'b0, s21} - {1'b0, r_lo});
        den     = r_up - r_lo;
    end

    assign wr_en     = (r_state == S_UPD) && (r_job.kind != K_NONE);
    assign div_start = (r_state == S_UPD) && (r_job.kind == K_NORM) && !upd_err;
    assign out_load  = (r_state == S_OUT) && (!r_ov || !i_out_stall);

    smcn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_mag   (mag),
        .i_den   (den),
        .i_neg   (num_neg),
        .o_done  (div_done),
        .o_norm  (div_norm),
        .o_sat   (div_sat)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (!i_q_stat.empty) n_state = S_MUL;
            S_MUL:  n_state = S_MEAN;
            S_MEAN: n_state = S_UPD;
            S_UPD:  n_state = div_start ? S_DIV : S_OUT;
            S_DIV:  if (div_done) n_state = S_OUT;
            S_OUT:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                r_valid[job_addr] <= 1'b1;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // bound table
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd  <= r_mem[head_addr];
            r_rdv <= r_valid[head_addr];
        end
        if (wr_en) begin
            r_mem[job_addr] <= {upd_u, upd_l};
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    r_job <= i_head;
                end
            end
            S_MUL: begin
                r_up <= r_rdv ? r_rd[41:21] : '0;
                r_lo <= r_rdv ? r_rd[20:0] : '0;
                r_pu <= 29'(r_job.mv) * 29'(scale_u);
                r_pl <= 29'(r_job.mv) * 29'(scale_l);
            end
            S_MEAN: r_mt <= mean_prod[52:32];
            S_UPD: begin
                r_nu   <= upd_u;
                r_nl   <= upd_l;
                r_err  <= upd_err;
                r_norm <= '0;
                r_sat  <= 1'b0;
            end
            S_DIV: begin
                if (div_done) begin
                    r_norm <= div_norm;
                    r_sat  <= div_sat;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_norm <= r_norm;
            r_o_err  <= r_err;
            r_o_sat  <= r_sat;
            r_o_up   <= r_nu;
            r_o_lo   <= r_nl;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_norm_value  = r_o_norm;
    assign o_bound_error = r_o_err;
    assign o_saturated   = r_o_sat;
    assign o_upper_now   = r_o_up;
    assign o_lower_now   = r_o_lo;

endmodule

>>> hw/rtl/sensor_minmax_calibrate_normalize.sv
// channel   direction  handshake                  word
// in        input      i_in_valid / o_in_stall     func, sensor_index, millivolts
// out       output     o_out_valid / i_out_stall   norm_value, bound_error, saturated,
//                                                  upper_now, lower_now
// cfg       input      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// in the back end a clear, calibration or degenerate-bound word runs mul, mean, upd, out,
// a normalize sample adds div: 24-step restoring division, cut short on quotient overflow
// a two-word queue lets the input side keep accepting while a result waits
// synchronous active-low reset; bound table reads as zero via per-entry valid bits
// o_cfg_ready is always high
module sensor_minmax_calibrate_normalize import smcn_pkg::*; #(
    parameter int SENSOR_COUNT = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_func,
    input  logic [5:0]         i_sensor_index,
    input  logic [11:0]        i_millivolts,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [23:0] o_norm_value,
    output logic               o_bound_error,
    output logic               o_saturated,
    output logic [20:0]        o_upper_now,
    output logic [20:0]        o_lower_now,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);

    t_cfg    r_cfg;
    t_job    push_job;
    t_job    head_job;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase            <= PH_NORM;
            r_cfg.upper_factor     <= '0;
            r_cfg.lower_factor     <= '0;
            r_cfg.inv_sample_count <= 24'hFFFFFF;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_PHASE:        r_cfg.phase            <= i_cfg_data[1:0];
                REG_UPPER_FACTOR: r_cfg.upper_factor     <= i_cfg_data[15:0];
                REG_LOWER_FACTOR: r_cfg.lower_factor     <= i_cfg_data[15:0];
                REG_INV_COUNT:    r_cfg.inv_sample_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    smcn_front #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_front (
        .i_in_valid     (i_in_valid),
        .i_func         (i_func),
        .i_sensor_index (i_sensor_index),
        .i_millivolts   (i_millivolts),
        .i_phase        (r_cfg.phase),
        .i_q_stat       (q_stat),
        .o_in_stall     (o_in_stall),
        .o_push         (push),
        .o_job          (push_job)
    );

    smcn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_stat  (q_stat)
    );

    smcn_back #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_head        (head_job),
        .i_q_stat      (q_stat),
        .o_pop         (pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_norm_value  (o_norm_value),
        .o_bound_error (o_bound_error),
        .o_saturated   (o_saturated),
        .o_upper_now   (o_upper_now),
        .o_lower_now   (o_lower_now)
    );

endmodule
